/* hdl/bcdtr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BCD time readout decoder package
// Shared types, status codes and digit helpers for the time readout decoder.
// ----------------------------------------------------------------------------
package bcdtr_pkg;

   localparam int WORD_W   = 16;
   localparam int MJD_W    = 17;
   localparam int MS_W     = 30;
   localparam int STATUS_W = 2;
   localparam int DAYF_W   = 12;

   // Status codes of a result word.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SIGNAL    = 2'd1;
   localparam int                  STATUS_BAD_DAY_I = 2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_DAY   = 2'(STATUS_BAD_DAY_I);

   // Status bit positions in the fourth readout word.
   localparam int SIGNAL_ERR_BIT = 12;
   localparam int LOCKED_BIT     = 13;

   // Queue between the classifier and the decode sequencer.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   typedef struct packed {
      logic lock_lost;
      logic signal_recovered;
      logic day_recovered;
      logic unlock_began;
      logic lock_regained;
   } notice_type;

   typedef struct packed {
      logic [WORD_W-1:0]   word0;
      logic [WORD_W-1:0]   word1;
      logic [WORD_W-1:0]   word2;
      logic [DAYF_W-1:0]   day_bcd;
      logic [STATUS_W-1:0] status;
      notice_type          notice;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Two-digit value, each nibble weighted as it stands (no range check).
   function automatic logic [7:0] dec2(input logic [3:0] tens, input logic [3:0] ones);
      dec2 = {4'd0, tens} * 8'd10 + {4'd0, ones};
   endfunction

   // Three-digit value, each nibble weighted as it stands.
   function automatic logic [10:0] dec3(input logic [3:0] hundreds, input logic [3:0] tens,
                                        input logic [3:0] ones);
      dec3 = {7'd0, hundreds} * 11'd100 + {7'd0, tens} * 11'd10 + {7'd0, ones};
   endfunction

endpackage

/* hdl/bcdtr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BCD time readout classifier
// Accepts readout words, classifies the status and updates the sticky flags.
// ----------------------------------------------------------------------------
module bcdtr_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bcdtr_pkg::WORD_W-1:0]      req_time_word0,
   input  logic [bcdtr_pkg::WORD_W-1:0]      req_time_word1,
   input  logic [bcdtr_pkg::WORD_W-1:0]      req_time_word2,
   input  logic [bcdtr_pkg::WORD_W-1:0]      req_time_word3,
   input  logic                              queue_full,
   output logic                              push,
   output bcdtr_pkg::entry_type              push_entry
);

   logic signal_seen_ff, signal_seen_in;
   logic bad_day_seen_ff, bad_day_seen_in;
   logic unlock_seen_ff, unlock_seen_in;
   logic signal_err, day_zero, locked;

   assign req_ready  = !queue_full;
   assign push       = req_valid && req_ready;
   assign signal_err = req_time_word3[bcdtr_pkg::SIGNAL_ERR_BIT];
   assign locked     = req_time_word3[bcdtr_pkg::LOCKED_BIT];
   assign day_zero   = (req_time_word3[bcdtr_pkg::DAYF_W-1:0] == '0);

   always_comb begin
      push_entry.word0   = req_time_word0;
      push_entry.word1   = req_time_word1;
      push_entry.word2   = req_time_word2;
      push_entry.day_bcd = req_time_word3[bcdtr_pkg::DAYF_W-1:0];
      push_entry.status  = bcdtr_pkg::STATUS_OK;
      push_entry.notice  = '0;
      signal_seen_in     = signal_seen_ff;
      bad_day_seen_in    = bad_day_seen_ff;
      unlock_seen_in     = unlock_seen_ff;
      if (signal_err) begin
         push_entry.status = bcdtr_pkg::STATUS_SIGNAL;
         signal_seen_in    = 1'b1;
      end else begin
         if (signal_seen_ff) begin
            signal_seen_in                     = 1'b0;
            push_entry.notice.signal_recovered = 1'b1;
         end
         if (day_zero) begin
            push_entry.status = bcdtr_pkg::STATUS_BAD_DAY;
            bad_day_seen_in   = 1'b1;
         end else begin
            if (bad_day_seen_ff) begin
               bad_day_seen_in                 = 1'b0;
               push_entry.notice.day_recovered = 1'b1;
            end
            if (!locked) begin
               push_entry.notice.lock_lost = 1'b1;
               if (!unlock_seen_ff) begin
                  unlock_seen_in                 = 1'b1;
                  push_entry.notice.unlock_began = 1'b1;
               end
            end else if (unlock_seen_ff) begin
               unlock_seen_in                  = 1'b0;
               push_entry.notice.lock_regained = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         signal_seen_ff  <= 1'b0;
         bad_day_seen_ff <= 1'b0;
         unlock_seen_ff  <= 1'b0;
      end else if (push) begin
         signal_seen_ff  <= signal_seen_in;
         bad_day_seen_ff <= bad_day_seen_in;
         unlock_seen_ff  <= unlock_seen_in;
      end
   end

endmodule

/* hdl/bcdtr_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BCD time readout queue
// Two-entry first-in first-out queue between classifier and decoder.
// ----------------------------------------------------------------------------
module bcdtr_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  bcdtr_pkg::entry_type        push_entry,
   input  logic                        pop,
   output bcdtr_pkg::entry_type        head_entry,
   output bcdtr_pkg::queue_status_type queue_status
);

   bcdtr_pkg::entry_type                 slot_ff [bcdtr_pkg::QUEUE_DEPTH];
   logic [bcdtr_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [bcdtr_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;

   assign head_entry         = slot_ff[rd_ptr_ff];
   assign queue_status.full  = (count_ff == bcdtr_pkg::QUEUE_CNT_W'(bcdtr_pkg::QUEUE_DEPTH));
   assign queue_status.empty = (count_ff == '0);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

/* hdl/bcdtr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BCD time readout decode sequencer
// Weights the BCD digits and builds the day number and millisecond of day.
// ----------------------------------------------------------------------------
module bcdtr_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [bcdtr_pkg::MJD_W-1:0]        year_start,
   input  bcdtr_pkg::entry_type               head_entry,
   input  logic                               queue_empty,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [bcdtr_pkg::MJD_W-1:0]        rsp_day_number_mjd,
   output logic [bcdtr_pkg::MS_W-1:0]         rsp_ms_of_day,
   output logic [bcdtr_pkg::STATUS_W-1:0]     rsp_status,
   output logic                               rsp_lock_lost,
   output logic                               rsp_signal_recovered,
   output logic                               rsp_day_recovered,
   output logic                               rsp_unlock_began,
   output logic                               rsp_lock_regained
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_HM   = 2'd1;
   localparam logic [1:0] ST_HMS  = 2'd2;
   localparam logic [1:0] ST_MS   = 2'd3;

   logic [1:0]                         state_ff, state_in;
   logic [7:0]                         hour_ff, min_ff, sec_ff;
   logic [10:0]                        msec_ff;
   logic [bcdtr_pkg::MJD_W-1:0]        day_ff;
   logic [bcdtr_pkg::STATUS_W-1:0]     status_ff;
   bcdtr_pkg::notice_type              notice_ff;
   logic [19:0]                        acc_ff, acc_in;
   logic                               load, finish, out_free;
   logic [10:0]                        msec_hi, usec_lo, dayno;
   logic [bcdtr_pkg::MS_W-1:0]         ms_full;

   logic                               rsp_valid_ff;
   logic [bcdtr_pkg::MJD_W-1:0]        rsp_day_ff;
   logic [bcdtr_pkg::MS_W-1:0]         rsp_ms_ff;
   logic [bcdtr_pkg::STATUS_W-1:0]     rsp_status_ff;
   bcdtr_pkg::notice_type              rsp_notice_ff;

   // Milliseconds from the upper three fractional digits; the lower three
   // can reach 1665 microseconds, which carries at most one millisecond.
   assign msec_hi = bcdtr_pkg::dec3(head_entry.word1[7:4], head_entry.word1[3:0],
                                    head_entry.word0[15:12]);
   assign usec_lo = bcdtr_pkg::dec3(head_entry.word0[11:8], head_entry.word0[7:4],
                                    head_entry.word0[3:0]);
   assign dayno   = bcdtr_pkg::dec3(head_entry.day_bcd[11:8], head_entry.day_bcd[7:4],
                                    head_entry.day_bcd[3:0]);
   assign ms_full = bcdtr_pkg::MS_W'(acc_ff) * 30'd1000 + bcdtr_pkg::MS_W'(msec_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      load     = 1'b0;
      finish   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               load     = 1'b1;
               state_in = ST_HM;
            end
         end
         ST_HM: begin
            acc_in   = 20'(hour_ff) * 20'd60 + 20'(min_ff);
            state_in = ST_HMS;
         end
         ST_HMS: begin
            acc_in   = acc_ff * 20'd60 + 20'(sec_ff);
            state_in = ST_MS;
         end
         ST_MS: begin
            if (out_free) begin
               finish = 1'b1;
               if (!queue_empty) begin
                  load     = 1'b1;
                  state_in = ST_HM;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign pop = load;

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (load) begin
         hour_ff   <= bcdtr_pkg::dec2(head_entry.word2[15:12], head_entry.word2[11:8]);
         min_ff    <= bcdtr_pkg::dec2(head_entry.word2[7:4], head_entry.word2[3:0]);
         sec_ff    <= bcdtr_pkg::dec2(head_entry.word1[15:12], head_entry.word1[11:8]);
         msec_ff   <= msec_hi + 11'(usec_lo >= 11'd1000);
         day_ff    <= year_start + bcdtr_pkg::MJD_W'(dayno) - 17'd1;
         status_ff <= head_entry.status;
         notice_ff <= head_entry.notice;
      end
      if (finish) begin
         rsp_status_ff <= status_ff;
         rsp_notice_ff <= notice_ff;
         if (status_ff == bcdtr_pkg::STATUS_OK) begin
            rsp_day_ff <= day_ff;
            rsp_ms_ff  <= ms_full;
         end else begin
            rsp_day_ff <= '0;
            rsp_ms_ff  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_day_number_mjd   = rsp_day_ff;
   assign rsp_ms_of_day        = rsp_ms_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_lock_lost        = rsp_notice_ff.lock_lost;
   assign rsp_signal_recovered = rsp_notice_ff.signal_recovered;
   assign rsp_day_recovered    = rsp_notice_ff.day_recovered;
   assign rsp_unlock_began     = rsp_notice_ff.unlock_began;
   assign rsp_lock_regained    = rsp_notice_ff.lock_regained;

endmodule

/* hdl/bcd_time_readout_decoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BCD time readout decoder core
// Decodes a four-word BCD time snapshot into a day number and ms of day.
// ----------------------------------------------------------------------------
// A request word passes the queue, the digit registers and three multiply
// steps (hours to minutes, minutes to seconds, seconds to ms) to the output
// register. Words are decoded one at a time; a stalled output holds them.
// Reset (synchronous, active high) empties the queue and output register,
// clears the three sticky flags and sets year_start_mjd to zero.
// ----------------------------------------------------------------------------
module bcd_time_readout_decoder_core (
   input  logic                               clock,
   input  logic                               reset,
   // Configuration write channel.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bcdtr_pkg::MJD_W-1:0]        csr_year_start_mjd,
   // Request channel: one snapshot of four readout words.
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [bcdtr_pkg::WORD_W-1:0]       req_time_word0,
   input  logic [bcdtr_pkg::WORD_W-1:0]       req_time_word1,
   input  logic [bcdtr_pkg::WORD_W-1:0]       req_time_word2,
   input  logic [bcdtr_pkg::WORD_W-1:0]       req_time_word3,
   // Response channel.
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [bcdtr_pkg::MJD_W-1:0]        rsp_day_number_mjd,
   output logic [bcdtr_pkg::MS_W-1:0]         rsp_ms_of_day,
   output logic [bcdtr_pkg::STATUS_W-1:0]     rsp_status,
   output logic                               rsp_lock_lost,
   output logic                               rsp_signal_recovered,
   output logic                               rsp_day_recovered,
   output logic                               rsp_unlock_began,
   output logic                               rsp_lock_regained
);

   logic [bcdtr_pkg::MJD_W-1:0]   year_start_ff;
   logic                          push, pop;
   bcdtr_pkg::entry_type          push_entry, head_entry;
   bcdtr_pkg::queue_status_type   queue_status;

   // The year start register takes a write in any cycle. The user must change
   // it only while the decoder is idle; the core does not enforce this.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         year_start_ff <= '0;
      end else if (csr_valid) begin
         year_start_ff <= csr_year_start_mjd;
      end
   end

   // The classifier settles status and the transition notices at accept
   // time, so the sticky flags follow the order of the request words.
   bcdtr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_time_word0 (req_time_word0),
      .req_time_word1 (req_time_word1),
      .req_time_word2 (req_time_word2),
      .req_time_word3 (req_time_word3),
      .queue_full     (queue_status.full),
      .push           (push),
      .push_entry     (push_entry)
   );

   // The queue lets the classifier keep taking words while the sequencer
   // works or the response side stalls.
   bcdtr_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_entry   (push_entry),
      .pop          (pop),
      .head_entry   (head_entry),
      .queue_status (queue_status)
   );

   // The sequencer weights the digits and holds the result in the output
   // register until the response side takes it.
   bcdtr_back u_back (
      .clock                (clock),
      .reset                (reset),
      .year_start           (year_start_ff),
      .head_entry           (head_entry),
      .queue_empty          (queue_status.empty),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_day_number_mjd   (rsp_day_number_mjd),
      .rsp_ms_of_day        (rsp_ms_of_day),
      .rsp_status           (rsp_status),
      .rsp_lock_lost        (rsp_lock_lost),
      .rsp_signal_recovered (rsp_signal_recovered),
      .rsp_day_recovered    (rsp_day_recovered),
      .rsp_unlock_began     (rsp_unlock_began),
      .rsp_lock_regained    (rsp_lock_regained)
   );

endmodule

/* hdl/bcdtr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BCD time readout checker
// Port-level checks of the decoder core, attached with a bind statement.
// ----------------------------------------------------------------------------
module bcdtr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [bcdtr_pkg::MJD_W-1:0]        rsp_day_number_mjd,
   input logic [bcdtr_pkg::MS_W-1:0]         rsp_ms_of_day,
   input logic [bcdtr_pkg::STATUS_W-1:0]     rsp_status,
   input logic                               rsp_lock_lost,
   input logic                               rsp_signal_recovered,
   input logic                               rsp_day_recovered,
   input logic                               rsp_unlock_began,
   input logic                               rsp_lock_regained
);

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ms_of_day)
         && $stable(rsp_day_number_mjd) && $stable(rsp_status))
      else $error("response word changed while stalled");

   // An error word carries no time.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bcdtr_pkg::STATUS_OK |->
         rsp_day_number_mjd == '0 && rsp_ms_of_day == '0)
      else $error("error word carries a time");

   // A signal error word raises no lock flag and no notice.
   a_sig_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bcdtr_pkg::STATUS_SIGNAL |->
         !rsp_lock_lost && !rsp_signal_recovered && !rsp_day_recovered
         && !rsp_unlock_began && !rsp_lock_regained)
      else $error("signal error word raised a flag");

   // A bad-day word reports no lock change and no day recovery.
   a_day_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bcdtr_pkg::STATUS_BAD_DAY |->
         !rsp_lock_lost && !rsp_day_recovered && !rsp_unlock_began && !rsp_lock_regained)
      else $error("bad-day word raised a lock flag");

   // Lock cannot be both regained and lost in the same word.
   a_lock_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lock_regained |-> !rsp_lock_lost && !rsp_unlock_began)
      else $error("lock regained and lost together");

endmodule

bind bcd_time_readout_decoder_core bcdtr_checker u_bcdtr_checker (.*);
